>>> sv/gsl_pkg.sv
// Shared constants and the sequencer state type for the glyph substitution lookup.
// No dependencies; imported by glyph_substitution_lookup_core.
`timescale 1ns / 1ps
`default_nettype none

package gsl_pkg;

   localparam int TABLE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(TABLE_BYTES);
   // Walk pointer: a record start is below TABLE_BYTES and a skip adds at most
   // 6 * 65535 + 3, so 20 bits never wrap for any table size up to 64 KiB.
   localparam int PTR_W       = 20;
   localparam int GLYPH_W     = 16;
   localparam int COV_W       = GLYPH_W + 1;

   localparam logic [7:0] END_MARK   = 8'd255;
   localparam logic [7:0] KIND_LIST  = 8'd1;
   localparam logic [7:0] KIND_DELTA = 8'd1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FETCH,
      S_BYTE0,
      S_BYTE1,
      S_KIND,
      S_KIND_CHK,
      S_COUNT,
      S_LOOP,
      S_LIST_CMP,
      S_RANGE_LO,
      S_RANGE_HI,
      S_RANGE_CHK,
      S_SKIP,
      S_TARGET,
      S_DELTA,
      S_COUNT_M,
      S_GLYPH,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> sv/glyph_substitution_lookup_core.sv
// Glyph substitution lookup: byte table memory plus a record-walking sequencer.
// Depends on gsl_pkg for sizes, table codes and the sequencer state type.
//
// A load request (tuser = 0) writes one table byte; the block is ready again the next cycle.
// A lookup request (tuser = 1) walks the table records from address 0 through the single
// read port of the table memory, one byte at a time; a 16-bit word is read as two bytes.
// Each record is opened by reading its type byte and count, and its glyph list entries or
// ranges are then compared in turn. An unmatched record is passed by reading its target
// kind; with a glyph list target its count is read and the list itself is skipped, not
// read. A matching record finishes the walk instead of reaching the end mark. An absent
// table answers without reading the table, and a walk that leaves memory stops at the
// offending read. The walk length is set by the table contents and the query glyph; the
// request side is not ready during the walk. The final state repeats while the response
// register is still full; once the result is loaded the next request is accepted while
// the result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module glyph_substitution_lookup_core
   import gsl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,    // table_present
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,      // load_address[11:0], load_byte[19:12],
                                            // query_glyph[35:20], zero fill
   input  wire logic        req_tuser,      // mode: 0 load byte, 1 lookup
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata       // result_glyph[15:0], substituted[16], zero fill
);

   logic [7:0] mem [TABLE_BYTES];
   logic [7:0] rd_data_ff;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      wide_ff, wide_in;

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   base_ff, base_in;
   logic [GLYPH_W-1:0] cnt_ff, cnt_in;
   logic [GLYPH_W-1:0] idx_ff, idx_in;
   logic [GLYPH_W-1:0] word_ff, word_in;
   logic [GLYPH_W-1:0] lo_ff, lo_in;
   logic [GLYPH_W-1:0] hi_ff, hi_in;
   logic [GLYPH_W-1:0] glyph_ff, glyph_in;
   logic [GLYPH_W-1:0] res_ff, res_in;
   logic [COV_W-1:0]   cov_ff, cov_in;
   logic               list_src_ff, list_src_in;
   logic               found_ff, found_in;
   logic               hit_ff, hit_in;
   logic               present_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               ptr_oob;
   logic               slot_free;
   logic [11:0]        ld_addr;
   logic [7:0]         ld_byte;
   logic [GLYPH_W-1:0] ld_glyph;
   logic [PTR_W-1:0]   ld_ext;
   logic               ld_ok;
   logic               in_range;
   logic               target_delta;
   logic [PTR_W-1:0]   span;

   assign ld_addr  = req_tdata[11:0];
   assign ld_byte  = req_tdata[19:12];
   assign ld_glyph = req_tdata[35:20];
   assign ld_ext   = PTR_W'(ld_addr);
   assign ld_ok    = ld_ext < PTR_W'(TABLE_BYTES);

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign ptr_oob    = ptr_ff >= PTR_W'(TABLE_BYTES);
   assign slot_free  = ~rsp_valid_ff | rsp_tready;
   assign in_range   = (lo_ff <= glyph_ff) && (glyph_ff <= hi_ff);
   assign target_delta = (word_ff[7:0] == KIND_DELTA);

   // bytes covered by the source entries: 2 per glyph, 6 per range
   assign span = list_src_ff ? PTR_W'({cnt_ff, 1'b0})
                             : PTR_W'({cnt_ff, 2'b00}) + PTR_W'({cnt_ff, 1'b0});

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // table memory: one write port for loads, one registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (req_accept && !req_tuser && ld_ok) begin
         mem[ld_ext[ADDR_W-1:0]] <= ld_byte;
      end
      rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
   end

   // next state; S_FETCH/S_BYTE0/S_BYTE1 form a read routine returning to ret_ff
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      wide_in  = wide_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_tuser) begin
               state_in = present_ff ? S_KIND : S_DONE;
            end
         end
         S_FETCH: begin
            state_in = ptr_oob ? S_DONE : S_BYTE0;
         end
         S_BYTE0: begin
            if (wide_ff) begin
               state_in = ptr_oob ? S_DONE : S_BYTE1;
            end else begin
               state_in = ret_ff;
            end
         end
         S_BYTE1: begin
            state_in = ret_ff;
         end
         S_KIND: begin
            state_in = S_FETCH;
            ret_in   = S_KIND_CHK;
            wide_in  = 1'b0;
         end
         S_KIND_CHK: begin
            if (word_ff[7:0] == END_MARK) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FETCH;
               ret_in   = S_COUNT;
               wide_in  = 1'b1;
            end
         end
         S_COUNT: begin
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (idx_ff == cnt_ff) begin
               state_in = S_SKIP;
            end else begin
               state_in = S_FETCH;
               ret_in   = list_src_ff ? S_LIST_CMP : S_RANGE_LO;
               wide_in  = 1'b1;
            end
         end
         S_LIST_CMP: begin
            state_in = (word_ff == glyph_ff) ? S_SKIP : S_LOOP;
         end
         S_RANGE_LO: begin
            state_in = S_FETCH;
            ret_in   = S_RANGE_HI;
            wide_in  = 1'b1;
         end
         S_RANGE_HI: begin
            state_in = S_FETCH;
            ret_in   = S_RANGE_CHK;
            wide_in  = 1'b1;
         end
         S_RANGE_CHK: begin
            state_in = in_range ? S_SKIP : S_LOOP;
         end
         S_SKIP: begin
            state_in = S_FETCH;
            ret_in   = S_TARGET;
            wide_in  = 1'b0;
         end
         S_TARGET: begin
            if (target_delta && !found_ff) begin
               state_in = S_KIND;
            end else begin
               state_in = S_FETCH;
               ret_in   = target_delta ? S_DELTA : S_COUNT_M;
               wide_in  = 1'b1;
            end
         end
         S_DELTA: begin
            state_in = S_DONE;
         end
         S_COUNT_M: begin
            if (!found_ff) begin
               state_in = S_KIND;
            end else if (cov_ff >= COV_W'(word_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FETCH;
               ret_in   = S_GLYPH;
               wide_in  = 1'b1;
            end
         end
         S_GLYPH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath registers driven by the sequencer
   always_comb begin
      ptr_in      = ptr_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      word_in     = word_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      glyph_in    = glyph_ff;
      res_in      = res_ff;
      cov_in      = cov_ff;
      list_src_in = list_src_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_tuser) begin
               glyph_in = ld_glyph;
               res_in   = ld_glyph;
               hit_in   = 1'b0;
               ptr_in   = '0;
            end
         end
         S_FETCH: begin
            if (!ptr_oob) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         S_BYTE0: begin
            word_in = {8'd0, rd_data_ff};
            if (wide_ff && !ptr_oob) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         S_BYTE1: begin
            word_in = {rd_data_ff, word_ff[7:0]};
         end
         S_KIND_CHK: begin
            list_src_in = (word_ff[7:0] == KIND_LIST);
         end
         S_COUNT: begin
            cnt_in   = word_ff;
            base_in  = ptr_ff;
            idx_in   = '0;
            found_in = 1'b0;
         end
         S_LIST_CMP: begin
            if (word_ff == glyph_ff) begin
               found_in = 1'b1;
               cov_in   = COV_W'(idx_ff);
            end else begin
               idx_in = idx_ff + GLYPH_W'(1);
            end
         end
         S_RANGE_LO: begin
            lo_in = word_ff;
         end
         S_RANGE_HI: begin
            hi_in = word_ff;
         end
         S_RANGE_CHK: begin
            if (in_range) begin
               found_in = 1'b1;
               cov_in   = COV_W'(glyph_ff - lo_ff) + COV_W'(word_ff);
            end else begin
               idx_in = idx_ff + GLYPH_W'(1);
            end
         end
         S_SKIP: begin
            ptr_in = base_ff + span;
         end
         S_TARGET: begin
            if (target_delta && !found_ff) begin
               ptr_in = ptr_ff + PTR_W'(2);
            end
         end
         S_DELTA: begin
            res_in = glyph_ff + word_ff;
            hit_in = 1'b1;
         end
         S_COUNT_M: begin
            if (!found_ff) begin
               ptr_in = ptr_ff + PTR_W'({word_ff, 1'b0});
            end else if (cov_ff < COV_W'(word_ff)) begin
               ptr_in = ptr_ff + PTR_W'({cov_ff, 1'b0});
            end
         end
         S_GLYPH: begin
            res_in = word_ff;
            hit_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, hit_ff, res_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         wide_ff      <= 1'b0;
         present_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         wide_ff      <= wide_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            present_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      glyph_ff    <= glyph_in;
      res_ff      <= res_in;
      cov_ff      <= cov_in;
      list_src_ff <= list_src_in;
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
